[rtl/tpc_pkg.sv]
// tpc_pkg: shared types, constants and register codes for the compensation pipeline.
// No dependencies.
`timescale 1ns / 1ps
package tpc_pkg;

   localparam int unsigned DivSteps = 64;
   localparam logic [31:0] FineOffset = 32'd128000;
   localparam logic [63:0] PressFull = 64'd1048576;
   localparam logic [63:0] PressScale = 64'd3125;

   typedef enum logic [1:0] {
      REG_TEMP      = 2'd0,
      REG_PRESS_LOW = 2'd1,
      REG_PRESS_MID = 2'd2,
      REG_PRESS_LST = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coeff_type;

   // Item leaving the front end, entering the divider.
   typedef struct packed {
      logic [31:0] temperature;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_in_type;

   // Item leaving the divider.
   typedef struct packed {
      logic [31:0] temperature;
      logic [63:0] quotient;
      logic        invalid;
   } div_out_type;

endpackage

[rtl/tpc_front.sv]
// tpc_front: temperature path and pressure dividend/divisor, pipelined.
// Depends on tpc_pkg.
`timescale 1ns / 1ps
module tpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [19:0]          raw_t,
   input  logic [19:0]          raw_p,
   input  tpc_pkg::coeff_type   coef,
   output logic                 out_valid,
   output tpc_pkg::div_in_type  out_data
);
   // stage 1: first products of temperature path
   logic [4:0] vld_ff;
   logic [31:0] s1_x1p_ff, s1_dd_ff;
   logic [19:0] s1_p_ff;
   logic [31:0] a_w, d_w;
   // stage 2
   logic [31:0] s2_x1_ff, s2_dds_ff;
   logic [19:0] s2_p_ff;
   // stage 3
   logic [31:0] s3_fine_ff;
   logic [19:0] s3_p_ff;
   logic [31:0] x2p_w;
   // stage 4
   logic [31:0] s4_temp_ff;
   logic [63:0] s4_v1_ff, s4_v1sq_ff;
   logic [19:0] s4_p_ff;
   logic signed [32:0] v1n_w;
   logic signed [65:0] v1sq_w;
   // stage 5
   logic [31:0] s5_temp_ff;
   logic [63:0] s5_a_ff, s5_b_ff, s5_c_ff, s5_d_ff, s5_pp_ff;
   logic [63:0] v1sum_w, v2_w;
   // stage 6 output
   logic [31:0] s6_temp_ff;
   logic [63:0] s6_num_ff, s6_v1_ff;
   logic [63:0] s5b_num_ff, s5b_v1s_ff;
   logic [31:0] s5b_temp_ff;
   logic        s5b_vld_ff;
   logic        s6_vld_ff;

   assign a_w = {15'd0, raw_t[19:3]} - {15'd0, coef.t1, 1'b0};
   assign d_w = {16'd0, raw_t[19:4]} - {16'd0, coef.t1};
   assign x2p_w = 32'($signed(s2_dds_ff) * 32'($signed(coef.t3)));

   // Fine temperature minus offset fits 33 signed bits, so its square stays narrow.
   assign v1n_w = 33'($signed(s3_fine_ff)) - {1'b0, tpc_pkg::FineOffset};
   assign v1sq_w = v1n_w * v1n_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         s5b_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= {vld_ff[3:0], in_valid};
         s5b_vld_ff <= vld_ff[4];
         s6_vld_ff <= s5b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x1p_ff <= 32'($signed(a_w) * 32'($signed(coef.t2)));
         s1_dd_ff <= d_w * d_w;
         s1_p_ff <= raw_p;
         s2_x1_ff <= 32'($signed(s1_x1p_ff) >>> 11);
         s2_dds_ff <= 32'($signed(s1_dd_ff) >>> 12);
         s2_p_ff <= s1_p_ff;
         s3_fine_ff <= s2_x1_ff + 32'($signed(x2p_w) >>> 14);
         s3_p_ff <= s2_p_ff;
         s4_temp_ff <= 32'($signed(s3_fine_ff * 32'd5 + 32'd128) >>> 8);
         s4_v1_ff <= 64'(v1n_w);
         s4_v1sq_ff <= v1sq_w[63:0];
         s4_p_ff <= s3_p_ff;
         s5_temp_ff <= s4_temp_ff;
         s5_a_ff <= s4_v1sq_ff * 64'($signed(coef.p6));
         s5_b_ff <= s4_v1_ff * 64'($signed(coef.p5));
         s5_c_ff <= s4_v1sq_ff * 64'($signed(coef.p3));
         s5_d_ff <= s4_v1_ff * 64'($signed(coef.p2));
         s5_pp_ff <= (tpc_pkg::PressFull - {44'd0, s4_p_ff}) << 31;
         s5b_temp_ff <= s5_temp_ff;
         s5b_num_ff <= s5_pp_ff - v2_w;
         s5b_v1s_ff <= (64'h0000_8000_0000_0000 + v1sum_w);
         s6_temp_ff <= s5b_temp_ff;
         s6_num_ff <= s5b_num_ff * tpc_pkg::PressScale;
         s6_v1_ff <= 64'($signed(s5b_v1s_ff * {48'd0, coef.p1}) >>> 33);
      end
   end

   assign v2_w = s5_a_ff + (s5_b_ff << 17) + (64'($signed(coef.p4)) << 35);
   assign v1sum_w = 64'($signed(s5_c_ff) >>> 8) + (s5_d_ff << 12);

   assign out_valid = s6_vld_ff;
   assign out_data.temperature = s6_temp_ff;
   assign out_data.dividend = s6_num_ff;
   assign out_data.divisor = s6_v1_ff;
endmodule

[rtl/tpc_div.sv]
// tpc_div: pipelined signed 64-bit restoring divider, one quotient bit per stage.
// Depends on tpc_pkg.
`timescale 1ns / 1ps
module tpc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  tpc_pkg::div_in_type   in_data,
   output logic                  out_valid,
   output tpc_pkg::div_out_type  out_data
);
   localparam int unsigned N = tpc_pkg::DivSteps;

   logic [N:0]    vld_ff;
   logic [63:0]   rem_ff [N+1];
   logic [63:0]   quo_ff [N+1];
   logic [63:0]   dvs_ff [N+1];
   logic [N:0]    neg_ff;
   logic [N:0]    zero_ff;
   logic [31:0]   tmp_ff [N+1];
   logic [63:0]   ma_w, mb_w;

   assign ma_w = in_data.dividend[63] ? 64'(0) - in_data.dividend : in_data.dividend;
   assign mb_w = in_data.divisor[63] ? 64'(0) - in_data.divisor : in_data.divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= ma_w;
         dvs_ff[0] <= mb_w;
         neg_ff[0] <= in_data.dividend[63] ^ in_data.divisor[63];
         zero_ff[0] <= (in_data.divisor == '0);
         tmp_ff[0] <= in_data.temperature;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      logic [64:0] sh_w, df_w;
      assign sh_w = {rem_ff[i], quo_ff[i][63]};
      assign df_w = sh_w - {1'b0, dvs_ff[i]};
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1] <= df_w[64] ? sh_w[63:0] : df_w[63:0];
            quo_ff[i+1] <= {quo_ff[i][62:0], ~df_w[64]};
            dvs_ff[i+1] <= dvs_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            zero_ff[i+1] <= zero_ff[i];
            tmp_ff[i+1] <= tmp_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_data.temperature = tmp_ff[N];
   assign out_data.quotient = neg_ff[N] ? 64'(0) - quo_ff[N] : quo_ff[N];
   assign out_data.invalid = zero_ff[N];
endmodule

[rtl/tpc_back.sv]
// tpc_back: post-division pressure correction, three stages.
// Depends on tpc_pkg.
`timescale 1ns / 1ps
module tpc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  tpc_pkg::div_out_type  in_data,
   input  tpc_pkg::coeff_type    coef,
   output logic                  out_valid,
   output logic [31:0]           temperature,
   output logic [31:0]           pressure,
   output logic                  invalid
);
   logic [2:0]  vld_ff;
   logic [31:0] t_ff [3];
   logic [2:0]  inv_ff;
   logic [63:0] p1_ff, ps_ff, w2p_ff, p2_ff, w1a_ff, w2_ff, p3_ff, w1p_ff;
   logic [31:0] press_w;
   logic [63:0] ps_w;
   logic [63:0] sq_ll_w;
   logic [31:0] sq_lh_w;

   assign ps_w = 64'($signed(in_data.quotient) >>> 13);

   // Low 64 bits of the square from 32-bit halves: low*low plus twice the cross term.
   assign sq_ll_w = {32'd0, ps_w[31:0]} * {32'd0, ps_w[31:0]};
   assign sq_lh_w = ps_w[31:0] * ps_w[63:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff[0] <= in_data.temperature;
         inv_ff[0] <= in_data.invalid;
         p1_ff <= in_data.quotient;
         ps_ff <= sq_ll_w + {sq_lh_w[30:0], 33'd0};
         w2p_ff <= in_data.quotient * 64'($signed(coef.p8));
         t_ff[1] <= t_ff[0];
         inv_ff[1] <= inv_ff[0];
         p2_ff <= p1_ff;
         w1a_ff <= ps_ff * 64'($signed(coef.p9));
         w2_ff <= 64'($signed(w2p_ff) >>> 19);
         t_ff[2] <= t_ff[1];
         inv_ff[2] <= inv_ff[1];
         p3_ff <= p2_ff + 64'($signed(w1a_ff) >>> 25) + w2_ff;
         w1p_ff <= 64'($signed(coef.p7)) << 4;
      end
   end

   always_comb begin
      press_w = 32'(64'($signed(p3_ff) >>> 8) + w1p_ff);
   end

   assign out_valid = vld_ff[2];
   assign temperature = t_ff[2];
   assign pressure = inv_ff[2] ? 32'd0 : press_w;
   assign invalid = inv_ff[2];
endmodule

[rtl/temp_pressure_compensation.sv]
// Barometric temperature/pressure compensation, fully pipelined.
// Pipeline: front end, divider, back end and an output register; one request
//   accepted per cycle while the output register is not stalled.
// The 64-step restoring divider, one quotient bit per stage, sets the depth.
// Synchronous active-high reset clears valid bits and calibration registers.
`timescale 1ns / 1ps
module temp_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_temperature,
   output logic [31:0] rsp_pressure,
   output logic        rsp_pressure_invalid,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   logic [47:0] tc_ff;
   logic [63:0] pl_ff, pm_ff;
   logic [15:0] p9_ff;
   tpc_pkg::coeff_type coef;
   tpc_pkg::reg_index_type idx;
   logic wr_en, advance;
   logic f_vld, d_vld, b_vld;
   tpc_pkg::div_in_type f_data;
   tpc_pkg::div_out_type d_data;
   logic [31:0] b_t, b_p;
   logic b_inv;
   logic out_vld_ff;
   logic [31:0] out_t_ff, out_p_ff;
   logic out_inv_ff;

   assign pready = 1'b1;
   assign idx = tpc_pkg::reg_index_type'(paddr[4:3]);
   assign wr_en = psel & penable & pwrite;

   // Calibration registers; decode on the register index bits only.
   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= '0;
         pl_ff <= '0;
         pm_ff <= '0;
         p9_ff <= '0;
      end else if (wr_en) begin
         unique case (idx)
            tpc_pkg::REG_TEMP:      tc_ff <= pwdata[47:0];
            tpc_pkg::REG_PRESS_LOW: pl_ff <= pwdata;
            tpc_pkg::REG_PRESS_MID: pm_ff <= pwdata;
            tpc_pkg::REG_PRESS_LST: p9_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         tpc_pkg::REG_TEMP:      prdata = {16'd0, tc_ff};
         tpc_pkg::REG_PRESS_LOW: prdata = pl_ff;
         tpc_pkg::REG_PRESS_MID: prdata = pm_ff;
         tpc_pkg::REG_PRESS_LST: prdata = {48'd0, p9_ff};
         default:                prdata = '0;
      endcase
   end

   assign coef.t1 = tc_ff[15:0];
   assign coef.t2 = tc_ff[31:16];
   assign coef.t3 = tc_ff[47:32];
   assign coef.p1 = pl_ff[15:0];
   assign coef.p2 = pl_ff[31:16];
   assign coef.p3 = pl_ff[47:32];
   assign coef.p4 = pl_ff[63:48];
   assign coef.p5 = pm_ff[15:0];
   assign coef.p6 = pm_ff[31:16];
   assign coef.p7 = pm_ff[47:32];
   assign coef.p8 = pm_ff[63:48];
   assign coef.p9 = p9_ff;

   // Whole pipeline moves when the output register is empty or being drained.
   assign advance = ~out_vld_ff | rsp_ready;
   assign req_ready = advance;

   tpc_front u_front (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid), .raw_t(req_raw_temperature), .raw_p(req_raw_pressure),
      .coef(coef), .out_valid(f_vld), .out_data(f_data)
   );

   tpc_div u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(f_vld), .in_data(f_data), .out_valid(d_vld), .out_data(d_data)
   );

   tpc_back u_back (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(d_vld), .in_data(d_data), .coef(coef),
      .out_valid(b_vld), .temperature(b_t), .pressure(b_p), .invalid(b_inv)
   );

   // Output register: hold while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= b_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_t_ff <= b_t;
         out_p_ff <= b_p;
         out_inv_ff <= b_inv;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_temperature = out_t_ff;
   assign rsp_pressure = out_p_ff;
   assign rsp_pressure_invalid = out_inv_ff;
endmodule

[rtl/tpc_checker.sv]
// tpc_checker: port-level properties of the compensation block.
// Bound to temp_pressure_compensation; no package use.
`timescale 1ns / 1ps
module tpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pressure,
   input logic        rsp_pressure_invalid,
   input logic        pready
);
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_invalid |-> rsp_pressure == 32'd0)
      else $error("invalid pressure not zero");
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pressure))
      else $error("result dropped under stall");
   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");
endmodule

bind temp_pressure_compensation tpc_checker u_tpc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_pressure(rsp_pressure),
   .rsp_pressure_invalid(rsp_pressure_invalid), .pready(pready)
);

[test/tpc_scoreboard.sv]
// tpc_scoreboard: watches the request, response and register ports of the
// compensation block, predicts each response and compares it. Depends on tpc_pkg.
`timescale 1ns / 1ps
module tpc_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_temperature,
   input  logic [31:0] rsp_pressure,
   input  logic        rsp_pressure_invalid,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          outstanding
);

   typedef struct {
      logic [31:0] temperature;
      logic [31:0] pressure;
      logic        invalid;
   } reading_type;

   logic [47:0] cal_temp;
   logic [63:0] cal_press_low;
   logic [63:0] cal_press_mid;
   logic [15:0] cal_press_last;
   reading_type compensated_q[$];

   function automatic logic [63:0] sext16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [31:0] shr32(logic [31:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] shr64(logic [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   // Truncating signed divide; the most negative value over -1 wraps.
   function automatic logic [63:0] quot64(logic [63:0] num, logic [63:0] den);
      logic [63:0] mn, md, q;
      mn = num[63] ? -num : num;
      md = den[63] ? -den : den;
      q = mn / md;
      return (num[63] != den[63]) ? -q : q;
   endfunction

   function automatic reading_type compensate(logic [19:0] raw_t, logic [19:0] raw_p);
      reading_type r;
      logic [31:0] adc_t, t1, t2, t3, a, x1, d, dd, x2, fine;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] v1, v2, p, ps, w1, w2;
      adc_t = {12'b0, raw_t};
      t1 = {16'b0, cal_temp[15:0]};
      t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
      t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
      p1 = {48'b0, cal_press_low[15:0]};
      p2 = sext16(cal_press_low[31:16]);
      p3 = sext16(cal_press_low[47:32]);
      p4 = sext16(cal_press_low[63:48]);
      p5 = sext16(cal_press_mid[15:0]);
      p6 = sext16(cal_press_mid[31:16]);
      p7 = sext16(cal_press_mid[47:32]);
      p8 = sext16(cal_press_mid[63:48]);
      p9 = sext16(cal_press_last);

      // temperature path wraps at 32 bits
      a = (adc_t >> 3) - (t1 << 1);
      a = a * t2;
      x1 = shr32(a, 11);
      d = (adc_t >> 4) - t1;
      dd = d * d;
      dd = shr32(dd, 12);
      dd = dd * t3;
      x2 = shr32(dd, 14);
      fine = x1 + x2;
      a = fine * 32'd5 + 32'd128;
      r.temperature = shr32(a, 8);

      // pressure path wraps at 64 bits
      v1 = {{32{fine[31]}}, fine} - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = shr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = shr64(((64'd1 << 47) + v1) * p1, 33);
      if (v1 == 64'd0) begin
         r.pressure = '0;
         r.invalid = 1'b1;
      end else begin
         p = 64'd1048576 - {44'b0, raw_p};
         p = quot64(((p << 31) - v2) * 64'd3125, v1);
         ps = shr64(p, 13);
         w1 = shr64(p9 * ps * ps, 25);
         w2 = shr64(p8 * p, 19);
         p = shr64(p + w1 + w2, 8) + (p7 << 4);
         r.pressure = p[31:0];
         r.invalid = 1'b0;
      end
      return r;
   endfunction

   assign outstanding = compensated_q.size();

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         cal_temp <= '0;
         cal_press_low <= '0;
         cal_press_mid <= '0;
         cal_press_last <= '0;
         compensated_q.delete();
         mismatches <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (tpc_pkg::reg_index_type'(paddr[4:3]))
               tpc_pkg::REG_TEMP:      cal_temp <= pwdata[47:0];
               tpc_pkg::REG_PRESS_LOW: cal_press_low <= pwdata;
               tpc_pkg::REG_PRESS_MID: cal_press_mid <= pwdata;
               tpc_pkg::REG_PRESS_LST: cal_press_last <= pwdata[15:0];
            endcase
         end
         if (req_valid && req_ready)
            compensated_q.push_back(compensate(req_raw_temperature, req_raw_pressure));
         if (rsp_valid && rsp_ready) begin
            if (compensated_q.size() == 0) begin
               $error("unexpected response: temperature %0d pressure %0h",
                      $signed(rsp_temperature), rsp_pressure);
               mismatches <= mismatches + 1;
            end else begin
               want = compensated_q.pop_front();
               if (rsp_temperature !== want.temperature ||
                   rsp_pressure !== want.pressure ||
                   rsp_pressure_invalid !== want.invalid) begin
                  mismatches <= mismatches + 1;
                  if (rsp_temperature !== want.temperature)
                     $error("temperature: expected %0d, actual %0d",
                            $signed(want.temperature), $signed(rsp_temperature));
                  if (rsp_pressure !== want.pressure)
                     $error("pressure: expected %0h, actual %0h",
                            want.pressure, rsp_pressure);
                  if (rsp_pressure_invalid !== want.invalid)
                     $error("pressure_invalid: expected %0b, actual %0b",
                            want.invalid, rsp_pressure_invalid);
               end
            end
         end
      end
   end

endmodule

[test/temp_pressure_compensation_tb.sv]
// temp_pressure_compensation_tb: drives requests and calibration writes into the
// compensation block and gives the verdict. Depends on tpc_pkg, tpc_scoreboard, temp_pressure_compensation.
`timescale 1ns / 1ps
module temp_pressure_compensation_tb;

   localparam int DrainCycles = 100;
   localparam int CycleLimit = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [19:0] req_raw_temperature;
   logic [19:0] req_raw_pressure;
   logic        rsp_valid;
   logic        rsp_ready;
   logic signed [31:0] rsp_temperature;
   logic [31:0] rsp_pressure;
   logic        rsp_pressure_invalid;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   int mismatches;
   int outstanding;
   int cycles = 0;

   temp_pressure_compensation dut (.*);

   tpc_scoreboard scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_raw_temperature(req_raw_temperature), .req_raw_pressure(req_raw_pressure),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_temperature(rsp_temperature), .rsp_pressure(rsp_pressure),
      .rsp_pressure_invalid(rsp_pressure_invalid),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: switch between random stall patterns - always ready,
   // coin toss, or mostly stalled.
   initial begin
      int mode;
      rsp_ready = 1'b0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (cycles % 64 == 0)
            mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            default: rsp_ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Write one calibration register: setup cycle, then access cycle.
   // Call at a falling edge; returns at a falling edge.
   task automatic write_cal(tpc_pkg::reg_index_type idx, logic [63:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 3'b000};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic load_cal(logic [47:0] tc, logic [63:0] lo, logic [63:0] mid,
                           logic [15:0] last);
      write_cal(tpc_pkg::REG_TEMP, {16'b0, tc});
      write_cal(tpc_pkg::REG_PRESS_LOW, lo);
      write_cal(tpc_pkg::REG_PRESS_MID, mid);
      write_cal(tpc_pkg::REG_PRESS_LST, {48'b0, last});
   endtask

   // Hold the request until accepted. Call at a falling edge; returns at one
   // with valid still high so the next request can replace it directly.
   task automatic send_reading(logic [19:0] raw_t, logic [19:0] raw_p);
      req_valid = 1'b1;
      req_raw_temperature = raw_t;
      req_raw_pressure = raw_p;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and let the pipeline empty before touching calibration.
   task automatic drain;
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // Random readings in bursts: mostly around realistic conversions,
   // some full range, some at the rails.
   task automatic random_readings(int count);
      int sent, burst, pick;
      logic [19:0] rt, rp;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < count; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               rt = 20'($urandom_range(400000, 600000));
               rp = 20'($urandom_range(250000, 450000));
            end else if (pick < 9) begin
               rt = 20'($urandom);
               rp = 20'($urandom);
            end else begin
               rt = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
               rp = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
            end
            send_reading(rt, rp);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   endtask

   initial begin
      logic [47:0] typ_temp;
      logic [63:0] typ_low, typ_mid;
      // typical factory calibration
      typ_temp = {16'hFC18, 16'd26435, 16'd27504};               // T3=-1000
      typ_low  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};       // P2=-10685
      typ_mid  = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};        // P8=-14600

      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_temperature = '0;
      req_raw_pressure = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Calibration still zero after reset: P1 is zero, so every pressure
      // must come back flagged invalid.
      send_reading(20'h00000, 20'h00000);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'd519888, 20'd415148);
      drain();

      // Typical calibration, rails and realistic readings.
      load_cal(typ_temp, typ_low, typ_mid, 16'd6000);
      send_reading(20'h00000, 20'h00000);
      send_reading(20'hFFFFF, 20'h00000);
      send_reading(20'h00000, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'd519888, 20'd415148);
      send_reading(20'h80000, 20'h80000);
      send_reading(20'h7FFFF, 20'h55555);
      send_reading(20'hAAAAA, 20'h7FFFF);
      req_valid = 1'b0;
      // pause until every result is back, then resume without reconfiguring
      while (outstanding != 0) @(negedge clock);
      send_reading(20'd500000, 20'd300000);
      send_reading(20'd600000, 20'd350000);
      random_readings(200);
      drain();

      // P1 zero with otherwise typical values: divisor is zero, temperature
      // still computed.
      load_cal(typ_temp, {typ_low[63:16], 16'h0000}, typ_mid, 16'd6000);
      send_reading(20'd519888, 20'd415148);
      send_reading(20'hFFFFF, 20'h00000);
      drain();

      // All ones: every signed coefficient -1, unsigned ones at maximum.
      load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               16'hFFFF);
      send_reading(20'h00000, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'h00000);
      random_readings(150);
      drain();

      // Most negative signed coefficients, maximum unsigned ones.
      load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
               64'h8000_8000_8000_8000, 16'h8000);
      send_reading(20'h00000, 20'h00000);
      random_readings(150);
      drain();

      // Most positive signed coefficients, smallest nonzero unsigned ones.
      load_cal({16'h7FFF, 16'h7FFF, 16'h0001}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
               64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
      random_readings(150);
      drain();

      // Several fully random calibration sets.
      for (int s = 0; s < 3; s++) begin
         load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                  {$urandom, $urandom}, 16'($urandom));
         random_readings(150);
         drain();
      end

      // Back to typical calibration for a final run.
      load_cal(typ_temp, typ_low, typ_mid, 16'd6000);
      random_readings(150);
      drain();

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
